@@ rtl/epsc_pkg.sv @@
package epsc_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_EDGE_A = 2'd0;
  localparam logic [1:0] OP_EDGE_B = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_I_GAIN         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_TO_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TO_COUNT = 3'd4;

  // Reset value of both scale factors: 1.0 in Q16.16
  localparam logic [31:0] SCALE_ONE = 32'h0001_0000;

  // Saturation limits
  localparam logic signed [15:0] SPEED_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SPEED_MIN = -16'sh8000;
  localparam logic signed [31:0] ERR_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ERR_MIN   = -32'sh8000_0000;
  localparam logic signed [39:0] SUM_MAX   = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] SUM_MIN   = -40'sh80_0000_0000;
  localparam logic [7:0]         DUTY_MAX  = 8'd255;

  // Operand selects of the shared multiplier
  localparam logic [2:0] MUL_SPD = 3'd0;
  localparam logic [2:0] MUL_ERR = 3'd1;
  localparam logic [2:0] MUL_P   = 3'd2;
  localparam logic [2:0] MUL_D   = 3'd3;
  localparam logic [2:0] MUL_ILO = 3'd4;
  localparam logic [2:0] MUL_IHI = 3'd5;

  // Accumulator operations
  localparam logic [1:0] ACC_HOLD   = 2'd0;
  localparam logic [1:0] ACC_LOAD   = 2'd1;
  localparam logic [1:0] ACC_ADD    = 2'd2;
  localparam logic [1:0] ACC_ADD_HI = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic               level_a;
    logic               level_b;
    logic signed [15:0] target_speed;
  } epsc_in_t;

  typedef struct packed {
    logic               direction;
    logic [7:0]         duty;
    logic signed [15:0] speed;
    logic signed [31:0] position;
  } epsc_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       ld_edge;
    logic       ld_target;
    logic       ld_last;
    logic [2:0] mul_sel;
    logic       ld_speed;
    logic       ld_err;
    logic       upd_sum;
    logic       upd_prev;
    logic [1:0] acc_op;
    logic       ld_drive;
    logic       ld_out;
  } epsc_cmd_t;

endpackage

@@ rtl/encoder_pid_speed_controller.sv @@
// An encoder edge goes from accept straight to the emit step; a control tick
// passes through a drive step before emit, paced by one shared 33x33 multiplier
// that forms speed, error, P, D and the two halves of the I product in turn.
// A new edge or tick is taken only in idle, once the last result has been emitted.
// Reset (rst_n low, synchronous): position, speed, error history and drive clear,
// direction forward, gains zero, both scale factors 1.0; config is always ready.
module encoder_pid_speed_controller import epsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  epsc_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output epsc_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  epsc_cmd_t cmd;

  assign cfg_ready = 1'b1;

  epsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  epsc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

@@ rtl/epsc_ctrl.sv @@
module epsc_ctrl import epsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_stall,
  input  logic       out_stall,
  output logic       out_valid,
  output epsc_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SPD     = 4'd1;
  localparam logic [3:0] S_ERR_MUL = 4'd2;
  localparam logic [3:0] S_ERR     = 4'd3;
  localparam logic [3:0] S_P       = 4'd4;
  localparam logic [3:0] S_D       = 4'd5;
  localparam logic [3:0] S_ILO     = 4'd6;
  localparam logic [3:0] S_IHI     = 4'd7;
  localparam logic [3:0] S_ACC     = 4'd8;
  localparam logic [3:0] S_DRIVE   = 4'd9;
  localparam logic [3:0] S_EMIT    = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // Sequence one item through the datapath
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = MUL_SPD;
    cmd.acc_op    = ACC_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_EDGE_A, OP_EDGE_B: begin
              cmd.ld_edge = 1'b1;
              state_nxt   = S_EMIT;
            end
            OP_TICK: begin
              cmd.ld_target = 1'b1;
              cmd.ld_last   = 1'b1;
              state_nxt     = S_SPD;
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_SPD: begin
        cmd.ld_speed = 1'b1;
        state_nxt    = S_ERR_MUL;
      end
      S_ERR_MUL: begin
        cmd.mul_sel = MUL_ERR;
        state_nxt   = S_ERR;
      end
      S_ERR: begin
        cmd.ld_err = 1'b1;
        state_nxt  = S_P;
      end
      S_P: begin
        cmd.mul_sel = MUL_P;
        cmd.upd_sum = 1'b1;
        state_nxt   = S_D;
      end
      S_D: begin
        cmd.mul_sel  = MUL_D;
        cmd.acc_op   = ACC_LOAD;
        cmd.upd_prev = 1'b1;
        state_nxt    = S_ILO;
      end
      S_ILO: begin
        cmd.mul_sel = MUL_ILO;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = S_IHI;
      end
      S_IHI: begin
        cmd.mul_sel = MUL_IHI;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.acc_op = ACC_ADD_HI;
        state_nxt  = S_DRIVE;
      end
      S_DRIVE: begin
        cmd.ld_drive = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result until the downstream side takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == S_EMIT && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("result raised outside the emit step");

  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_TICK) |=> state_r == S_SPD)
    else $error("tick did not start the speed step");

  a_edge_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_EDGE_A || in_op == OP_EDGE_B)) |=> state_r == S_EMIT)
    else $error("edge transaction did not go straight to emit");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("emit did not present the result and return to idle");
`endif

endmodule

@@ rtl/epsc_dpath.sv @@
module epsc_dpath import epsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  epsc_in_t             in_data,
  input  epsc_cmd_t            cmd,
  output epsc_out_t            out_data
);

  // Configuration registers
  logic signed [15:0] p_gain_r, i_gain_r, d_gain_r;
  logic [31:0]        c2s_r, s2c_r;

  // Controller state
  logic signed [31:0] pos_r, last_r;
  logic signed [15:0] speed_r, speed_nxt;
  logic signed [15:0] target_r;
  logic signed [31:0] err_r, err_nxt, prev_r;
  logic signed [39:0] sum_r, sum_nxt;
  logic               dir_r, dir_nxt;
  logic [7:0]         duty_r, duty_nxt;

  // Multiplier and accumulator
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] prod_r;
  logic signed [57:0] acc_r, acc_nxt;

  logic signed [31:0] diff;
  logic signed [16:0] serr;
  logic signed [32:0] derr;
  logic signed [32:0] p_ext, i_ext, d_ext;
  logic               same, up;
  logic signed [63:0] spd_b, err_b;
  logic signed [47:0] spd_q;
  logic signed [55:0] err_q;
  logic signed [40:0] sum_s;
  logic signed [57:0] u_b;
  logic signed [41:0] u_q, u_mag;
  epsc_out_t          out_r;

  assign diff  = pos_r - last_r;
  assign serr  = {target_r[15], target_r} - {speed_r[15], speed_r};
  assign derr  = {err_r[31], err_r} - {prev_r[31], prev_r};
  assign p_ext = {{17{p_gain_r[15]}}, p_gain_r};
  assign i_ext = {{17{i_gain_r[15]}}, i_gain_r};
  assign d_ext = {{17{d_gain_r[15]}}, d_gain_r};

  // Select multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SPD: begin
        mul_a = {diff[31], diff};
        mul_b = {1'b0, c2s_r};
      end
      MUL_ERR: begin
        mul_a = {{16{serr[16]}}, serr};
        mul_b = {1'b0, s2c_r};
      end
      MUL_P: begin
        mul_a = p_ext;
        mul_b = {err_r[31], err_r};
      end
      MUL_D: begin
        mul_a = d_ext;
        mul_b = derr;
      end
      MUL_ILO: begin
        mul_a = i_ext;
        mul_b = {13'b0, sum_r[19:0]};
      end
      MUL_IHI: begin
        mul_a = i_ext;
        mul_b = {{13{sum_r[39]}}, sum_r[39:20]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Speed: truncate toward zero, drop 16 fraction bits, saturate
  assign spd_b = prod_r + (prod_r[63] ? 64'sd65535 : 64'sd0);
  assign spd_q = spd_b[63:16];
  always_comb begin
    if (spd_q[47:15] != {33{spd_q[47]}}) begin
      speed_nxt = spd_q[47] ? SPEED_MIN : SPEED_MAX;
    end else begin
      speed_nxt = spd_q[15:0];
    end
  end

  // Error: truncate toward zero, drop 8 bits, saturate
  assign err_b = prod_r + (prod_r[63] ? 64'sd255 : 64'sd0);
  assign err_q = err_b[63:8];
  always_comb begin
    if (err_q[55:31] != {25{err_q[55]}}) begin
      err_nxt = err_q[55] ? ERR_MIN : ERR_MAX;
    end else begin
      err_nxt = err_q[31:0];
    end
  end

  // Integral: saturating add
  assign sum_s = {sum_r[39], sum_r} + {{9{err_r[31]}}, err_r};
  always_comb begin
    if (sum_s[40] != sum_s[39]) begin
      sum_nxt = sum_s[40] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = sum_s[39:0];
    end
  end

  // Accumulate the three terms
  always_comb begin
    unique case (cmd.acc_op)
      ACC_HOLD:   acc_nxt = acc_r;
      ACC_LOAD:   acc_nxt = prod_r[57:0];
      ACC_ADD:    acc_nxt = acc_r + prod_r[57:0];
      ACC_ADD_HI: acc_nxt = acc_r + {prod_r[37:0], 20'b0};
      default:    acc_nxt = acc_r;
    endcase
  end

  // Drive: truncate toward zero, split sign and clamped magnitude
  assign u_b   = acc_r + (acc_r[57] ? 58'sd65535 : 58'sd0);
  assign u_q   = u_b[57:16];
  assign u_mag = u_q[41] ? -u_q : u_q;
  always_comb begin
    dir_nxt  = !u_q[41];
    duty_nxt = (|u_mag[41:8]) ? DUTY_MAX : u_mag[7:0];
  end

  assign same = (in_data.level_a == in_data.level_b);
  assign up   = (in_data.operation == OP_EDGE_A) ? same : !same;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r <= '0;
      i_gain_r <= '0;
      d_gain_r <= '0;
      c2s_r    <= SCALE_ONE;
      s2c_r    <= SCALE_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_P_GAIN:         p_gain_r <= cfg_data[15:0];
        CFG_I_GAIN:         i_gain_r <= cfg_data[15:0];
        CFG_D_GAIN:         d_gain_r <= cfg_data[15:0];
        CFG_COUNT_TO_SPEED: c2s_r    <= cfg_data;
        CFG_SPEED_TO_COUNT: s2c_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Encoder and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      last_r  <= '0;
      speed_r <= '0;
      err_r   <= '0;
      prev_r  <= '0;
      sum_r   <= '0;
      acc_r   <= '0;
      dir_r   <= 1'b1;
      duty_r  <= '0;
    end else begin
      if (cmd.ld_edge) begin
        pos_r <= up ? pos_r + 32'sd1 : pos_r - 32'sd1;
      end
      if (cmd.ld_last) begin
        last_r <= pos_r;
      end
      if (cmd.ld_speed) begin
        speed_r <= speed_nxt;
      end
      if (cmd.ld_err) begin
        err_r <= err_nxt;
      end
      if (cmd.upd_sum) begin
        sum_r <= sum_nxt;
      end
      if (cmd.upd_prev) begin
        prev_r <= err_r;
      end
      acc_r <= acc_nxt;
      if (cmd.ld_drive) begin
        dir_r  <= dir_nxt;
        duty_r <= duty_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p[63:0];
    if (cmd.ld_target) begin
      target_r <= in_data.target_speed;
    end
    if (cmd.ld_out) begin
      out_r.direction <= dir_r;
      out_r.duty      <= duty_r;
      out_r.speed     <= speed_r;
      out_r.position  <= pos_r;
    end
  end

  assign out_data = out_r;

endmodule
